// ----- design/nawa_pkg.sv -----
package nawa_pkg;

    // table geometry
    localparam int NEIGHBOUR_COUNT = 16;
    localparam int TAB_AW = (NEIGHBOUR_COUNT > 1) ? $clog2(NEIGHBOUR_COUNT) : 1;

    // field widths
    localparam int OP_W   = 2;
    localparam int RAW_W  = 8;
    localparam int ID_W   = 4;
    localparam int PAY_W  = 4;
    localparam int DIST_W = 8;
    localparam int AGE_W  = 8;
    localparam int LIFE_W = 8;
    localparam int MASK_W = 16;

    // APB
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DIST_W-1:0] UNKNOWN_DISTANCE = 8'hFF;
    localparam logic [PAY_W-1:0]  VOID_PAYLOAD     = 4'h0;
    localparam logic [AGE_W-1:0]  AGE_MAX          = 8'hFF;
    localparam logic [LIFE_W-1:0] LIFETIME_RESET   = 8'd100;
    localparam logic [PAY_W-1:0]  PING_RESET       = 4'd1;

    // register index, taken from paddr[2]
    localparam logic REG_LIFETIME = 1'b0;
    localparam logic REG_PING     = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RECEIVE = 2'd0,
        OP_TICK    = 2'd1,
        OP_READ    = 2'd2,
        OP_ACK     = 2'd3
    } t_op;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic walk;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic walk_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/nawa_if.sv -----
interface nawa_in_if;
    import nawa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [RAW_W-1:0]    raw_message;
    logic [DIST_W-1:0]   measured_distance;
    logic [ID_W-1:0]     entry_index;

    modport source (
        output valid, operation, raw_message, measured_distance, entry_index,
        input  ready
    );
    modport sink (
        input  valid, operation, raw_message, measured_distance, entry_index,
        output ready
    );
endinterface

interface nawa_out_if;
    import nawa_pkg::*;

    logic                valid;
    logic                ready;
    logic                entry_present;
    logic [DIST_W-1:0]   entry_distance;
    logic [PAY_W-1:0]    entry_payload;
    logic [AGE_W-1:0]    entry_age;
    logic                payload_changed;
    logic [MASK_W-1:0]   expired_mask;
    logic [MASK_W-1:0]   present_mask;
    logic                new_message_flag;
    logic [PAY_W-1:0]    last_payload;

    modport source (
        output valid, entry_present, entry_distance, entry_payload, entry_age,
               payload_changed, expired_mask, present_mask, new_message_flag,
               last_payload,
        input  ready
    );
    modport sink (
        input  valid, entry_present, entry_distance, entry_payload, entry_age,
               payload_changed, expired_mask, present_mask, new_message_flag,
               last_payload,
        output ready
    );
endinterface

// ----- design/neighbour_archive_with_aging.sv -----
// Order: receive, read and acknowledge beats are accepted, executed, then loaded into the
//   result register once it is free; an aging tick first walks all 16 table entries in turn.
// Flow: one item in flight; a new item is accepted only after the last one is loaded into
//   the result register. A waiting result does not block the next acceptance.
// Reset: synchronous, active low; table cleared at once (absent, age 0, distance 255,
//   payload void), lifetime 100, ping code 1, no result pending.
module neighbour_archive_with_aging (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    nawa_in_if.sink                         i_item,
    nawa_out_if.source                      o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nawa_pkg::APB_AW-1:0]     paddr,
    input  logic [nawa_pkg::APB_DW-1:0]     pwdata,
    output logic [nawa_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import nawa_pkg::*;

    // config registers: lifetime at byte 0, ping code at byte 4
    logic [LIFE_W-1:0] r_lifetime;
    logic [PAY_W-1:0]  r_ping;
    logic              cfg_wr;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // only paddr[2] decodes; low bits are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
            r_ping     <= PING_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LIFETIME) begin
                r_lifetime <= pwdata[LIFE_W-1:0];
            end else begin
                r_ping <= pwdata[PAY_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PING) ? APB_DW'(r_ping) : APB_DW'(r_lifetime);

    // controller: accept -> execute or walk the table -> hand over to result register
    nawa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: item register, table, walk counter, result register
    nawa_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_lifetime          (r_lifetime),
        .i_ping              (r_ping),
        .i_operation         (i_item.operation),
        .i_raw_message       (i_item.raw_message),
        .i_measured_distance (i_item.measured_distance),
        .i_entry_index       (i_item.entry_index),
        .i_out_ready         (o_result.ready),
        .o_out_valid         (o_result.valid),
        .o_entry_present     (o_result.entry_present),
        .o_entry_distance    (o_result.entry_distance),
        .o_entry_payload     (o_result.entry_payload),
        .o_entry_age         (o_result.entry_age),
        .o_payload_changed   (o_result.payload_changed),
        .o_expired_mask      (o_result.expired_mask),
        .o_present_mask      (o_result.present_mask),
        .o_new_message_flag  (o_result.new_message_flag),
        .o_last_payload      (o_result.last_payload)
    );

endmodule

// ----- design/nawa_ctrl.sv -----
module nawa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nawa_pkg::t_dp_sts i_sts,
    output nawa_pkg::t_dp_cmd o_cmd
);
    import nawa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op == OP_TICK) begin
                    o_cmd.walk = 1'b1;
                    n_state    = i_sts.walk_last ? S_FIN : S_WALK;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_FIN;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/nawa_dp.sv -----
module nawa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nawa_pkg::t_dp_cmd             i_cmd,
    output nawa_pkg::t_dp_sts             o_sts,
    input  logic [nawa_pkg::LIFE_W-1:0]   i_lifetime,
    input  logic [nawa_pkg::PAY_W-1:0]    i_ping,
    input  logic [nawa_pkg::OP_W-1:0]     i_operation,
    input  logic [nawa_pkg::RAW_W-1:0]    i_raw_message,
    input  logic [nawa_pkg::DIST_W-1:0]   i_measured_distance,
    input  logic [nawa_pkg::ID_W-1:0]     i_entry_index,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_entry_present,
    output logic [nawa_pkg::DIST_W-1:0]   o_entry_distance,
    output logic [nawa_pkg::PAY_W-1:0]    o_entry_payload,
    output logic [nawa_pkg::AGE_W-1:0]    o_entry_age,
    output logic                          o_payload_changed,
    output logic [nawa_pkg::MASK_W-1:0]   o_expired_mask,
    output logic [nawa_pkg::MASK_W-1:0]   o_present_mask,
    output logic                          o_new_message_flag,
    output logic [nawa_pkg::PAY_W-1:0]    o_last_payload
);
    import nawa_pkg::*;

    // item held for the duration of its work
    t_op               r_op;
    logic [RAW_W-1:0]  r_raw;
    logic [DIST_W-1:0] r_meas;
    logic [ID_W-1:0]   r_sel;

    // neighbour table
    logic [NEIGHBOUR_COUNT-1:0] r_present;
    logic [AGE_W-1:0]           r_age  [NEIGHBOUR_COUNT];
    logic [DIST_W-1:0]          r_dist [NEIGHBOUR_COUNT];
    logic [PAY_W-1:0]           r_pay  [NEIGHBOUR_COUNT];
    logic [PAY_W-1:0]           r_notified;
    logic                       r_flag;

    logic [TAB_AW-1:0] r_walk;
    logic [MASK_W-1:0] r_expired;
    logic              r_changed;

    logic [ID_W-1:0]   item_id;
    logic [PAY_W-1:0]  rx_pay;
    logic [TAB_AW-1:0] addr;
    logic              addr_ok;
    logic              cur_present;
    logic [AGE_W-1:0]  cur_age;
    logic [DIST_W-1:0] cur_dist;
    logic [PAY_W-1:0]  cur_pay;

    logic              wr;
    logic              n_present_e;
    logic [AGE_W-1:0]  n_age_e;
    logic [DIST_W-1:0] n_dist_e;
    logic [PAY_W-1:0]  n_pay_e;
    logic              n_changed;
    logic              n_flag;
    logic [PAY_W-1:0]  n_notified;
    logic [MASK_W-1:0] n_expired;
    logic              is_read;

    assign item_id = (r_op == OP_RECEIVE) ? r_raw[RAW_W-1:PAY_W] : r_sel;
    assign rx_pay  = r_raw[PAY_W-1:0];
    assign addr    = i_cmd.walk ? r_walk : item_id[TAB_AW-1:0];
    assign addr_ok = i_cmd.walk ||
                     ({1'b0, item_id} < (ID_W+1)'(NEIGHBOUR_COUNT));

    assign cur_present = r_present[addr];
    assign cur_age     = r_age[addr];
    assign cur_dist    = r_dist[addr];
    assign cur_pay     = r_pay[addr];

    always_comb begin
        wr          = 1'b0;
        n_present_e = cur_present;
        n_age_e     = cur_age;
        n_dist_e    = cur_dist;
        n_pay_e     = cur_pay;
        n_changed   = r_changed;
        n_flag      = r_flag;
        n_notified  = r_notified;
        n_expired   = r_expired;
        if (i_cmd.exec) begin
            case (r_op)
                OP_RECEIVE: begin
                    if (addr_ok) begin
                        wr          = 1'b1;
                        n_present_e = 1'b1;
                        n_age_e     = '0;
                        n_dist_e    = r_meas;
                        if (rx_pay != cur_pay) begin
                            n_changed = 1'b1;
                            n_pay_e   = rx_pay;
                            if (rx_pay != VOID_PAYLOAD && rx_pay != i_ping) begin
                                n_notified = rx_pay;
                                n_flag     = 1'b1;
                            end
                        end
                    end
                end
                OP_ACK: begin
                    n_flag = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.walk && cur_present) begin
            wr = 1'b1;
            if (cur_age > i_lifetime) begin
                // expired: age kept, distance and payload back to unknown
                n_present_e = 1'b0;
                n_dist_e    = UNKNOWN_DISTANCE;
                n_pay_e     = VOID_PAYLOAD;
                n_expired   = r_expired | (MASK_W'(1) << r_walk);
            end else if (cur_age != AGE_MAX) begin
                n_age_e = cur_age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= t_op'(i_operation);
            r_raw  <= i_raw_message;
            r_meas <= i_measured_distance;
            r_sel  <= i_entry_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_notified <= VOID_PAYLOAD;
            r_flag     <= 1'b0;
            r_walk     <= '0;
            r_expired  <= '0;
            r_changed  <= 1'b0;
            for (int i = 0; i < NEIGHBOUR_COUNT; i++) begin
                r_age[i]  <= '0;
                r_dist[i] <= UNKNOWN_DISTANCE;
                r_pay[i]  <= VOID_PAYLOAD;
            end
        end else begin
            r_flag     <= n_flag;
            r_notified <= n_notified;
            if (i_cmd.load_item) begin
                r_walk    <= '0;
                r_expired <= '0;
                r_changed <= 1'b0;
            end else begin
                r_expired <= n_expired;
                r_changed <= n_changed;
                if (i_cmd.walk) begin
                    r_walk <= r_walk + TAB_AW'(1);
                end
            end
            if (wr) begin
                r_present[addr] <= n_present_e;
                r_age[addr]     <= n_age_e;
                r_dist[addr]    <= n_dist_e;
                r_pay[addr]     <= n_pay_e;
            end
        end
    end

    // result register
    assign is_read = (r_op == OP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_entry_present    <= is_read && addr_ok && cur_present;
            o_entry_distance   <= !is_read ? '0 : (addr_ok ? cur_dist : UNKNOWN_DISTANCE);
            o_entry_payload    <= (is_read && addr_ok) ? cur_pay : VOID_PAYLOAD;
            o_entry_age        <= (is_read && addr_ok) ? cur_age : '0;
            o_payload_changed  <= r_changed;
            o_expired_mask     <= r_expired;
            o_present_mask     <= MASK_W'(r_present);
            o_new_message_flag <= r_flag;
            o_last_payload     <= r_notified;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.walk_last = (r_walk == TAB_AW'(NEIGHBOUR_COUNT - 1));
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

endmodule

// ----- design/nawa_chk.sv -----
module nawa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_entry_present,
    input logic [nawa_pkg::DIST_W-1:0]   i_entry_distance,
    input logic [nawa_pkg::PAY_W-1:0]    i_entry_payload,
    input logic [nawa_pkg::AGE_W-1:0]    i_entry_age,
    input logic                          i_payload_changed,
    input logic [nawa_pkg::MASK_W-1:0]   i_expired_mask,
    input logic [nawa_pkg::MASK_W-1:0]   i_present_mask,
    input logic                          i_new_message_flag,
    input logic [nawa_pkg::PAY_W-1:0]    i_last_payload
);
    import nawa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_present_mask)
            && $stable(i_expired_mask) && $stable(i_entry_age)
            && $stable(i_last_payload))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in work");

    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_expired_mask != '0) |-> !i_entry_present && !i_payload_changed)
        else $error("tick beat carries read or receive fields");

    a_notify_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_new_message_flag |-> i_last_payload != VOID_PAYLOAD)
        else $error("notification raised with a void payload");

    a_expired_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_expired_mask & i_present_mask) == '0)
        else $error("expired entry still reported present");

endmodule

bind neighbour_archive_with_aging nawa_chk u_nawa_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_item.valid),
    .i_in_ready         (i_item.ready),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_entry_present    (o_result.entry_present),
    .i_entry_distance   (o_result.entry_distance),
    .i_entry_payload    (o_result.entry_payload),
    .i_entry_age        (o_result.entry_age),
    .i_payload_changed  (o_result.payload_changed),
    .i_expired_mask     (o_result.expired_mask),
    .i_present_mask     (o_result.present_mask),
    .i_new_message_flag (o_result.new_message_flag),
    .i_last_payload     (o_result.last_payload)
);

// ----- bench/neighbour_archive_with_aging_tb.sv -----
module neighbour_archive_with_aging_tb;
    import nawa_pkg::*;

    localparam int     HALF_PERIOD      = 5;
    localparam int     RESET_CYCLES     = 8;
    localparam int     MAX_WAIT         = 11;    // longest idle drawn by either side
    localparam int     RANDOM_BEATS     = 1520;
    localparam int     PHASES           = 8;
    localparam int     DRAIN_CYCLES     = 24;    // lets a tick's table walk finish, plus margin
    localparam int     LONG_HOLD        = 300;   // receiver hold-off to back the block up
    localparam int     CROWD_BEATS      = 40;    // back-to-back beats during the hold-off
    localparam int     SHOWN_MISMATCHES = 10;
    localparam longint WATCHDOG_CYCLES  = 500_000;

    // one input beat
    typedef struct {
        t_op               op;
        logic [RAW_W-1:0]  raw;
        logic [DIST_W-1:0] meas;
        logic [ID_W-1:0]   idx;
    } t_beat;

    // one result beat, fields in port order
    typedef struct packed {
        logic              present;
        logic [DIST_W-1:0] distance;
        logic [PAY_W-1:0]  pay;
        logic [AGE_W-1:0]  age;
        logic              changed;
        logic [MASK_W-1:0] expired;
        logic [MASK_W-1:0] present_mask;
        logic              flag;
        logic [PAY_W-1:0]  last_pay;
    } t_report;

    // ------------------------------------------------------------------
    // Shadow neighbour table. Every accepted input beat advances it and
    // queues the report the block owes; every result beat is checked
    // against the oldest queued report.
    // ------------------------------------------------------------------
    class table_tracker;
        logic [LIFE_W-1:0] lifetime;
        logic [PAY_W-1:0]  ping;
        logic              live     [NEIGHBOUR_COUNT];
        logic [AGE_W-1:0]  age      [NEIGHBOUR_COUNT];
        logic [DIST_W-1:0] distance [NEIGHBOUR_COUNT];
        logic [PAY_W-1:0]  pay      [NEIGHBOUR_COUNT];
        logic [PAY_W-1:0]  notified;
        logic              flag;
        t_report           awaited_reports [$];
        int                mismatches;
        int                expiries;
        int                notifications;
        int                settings;
        int                op_seen [4];

        function new();
            lifetime = LIFETIME_RESET;
            ping     = PING_RESET;
            for (int i = 0; i < NEIGHBOUR_COUNT; i++) begin
                live[i]     = 1'b0;
                age[i]      = '0;
                distance[i] = UNKNOWN_DISTANCE;
                pay[i]      = VOID_PAYLOAD;
            end
            notified      = VOID_PAYLOAD;
            flag          = 1'b0;
            mismatches    = 0;
            expiries      = 0;
            notifications = 0;
            settings      = 0;
            for (int i = 0; i < 4; i++) op_seen[i] = 0;
        endfunction

        function void set_register(logic idx, logic [APB_DW-1:0] value);
            if (idx == REG_LIFETIME) lifetime = value[LIFE_W-1:0];
            else                     ping     = value[PAY_W-1:0];
            settings++;
        endfunction

        function void note_beat(t_beat b);
            t_report          r;
            int               snd;
            logic [PAY_W-1:0] p;
            r = '0;
            op_seen[int'(b.op)]++;
            case (b.op)
                OP_RECEIVE: begin
                    snd = int'(b.raw[RAW_W-1 -: ID_W]);
                    p   = b.raw[PAY_W-1:0];
                    // senders beyond the table are dropped silently
                    if (snd < NEIGHBOUR_COUNT) begin
                        age[snd]      = '0;
                        live[snd]     = 1'b1;
                        distance[snd] = b.meas;
                        if (p != pay[snd]) begin
                            r.changed = 1'b1;
                            pay[snd]  = p;
                            if (p != VOID_PAYLOAD && p != ping) begin
                                notified = p;
                                flag     = 1'b1;
                                notifications++;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < NEIGHBOUR_COUNT; i++) begin
                        if (live[i]) begin
                            if (age[i] > lifetime) begin
                                // expired entry keeps its age
                                live[i]      = 1'b0;
                                distance[i]  = UNKNOWN_DISTANCE;
                                pay[i]       = VOID_PAYLOAD;
                                r.expired[i] = 1'b1;
                                expiries++;
                            end else if (age[i] != AGE_MAX) begin
                                age[i] = age[i] + 1'b1;
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (int'(b.idx) < NEIGHBOUR_COUNT) begin
                        r.present  = live[b.idx];
                        r.distance = distance[b.idx];
                        r.pay      = pay[b.idx];
                        r.age      = age[b.idx];
                    end else begin
                        r.distance = UNKNOWN_DISTANCE;
                    end
                end
                default: flag = 1'b0;
            endcase
            for (int i = 0; i < NEIGHBOUR_COUNT; i++) r.present_mask[i] = live[i];
            r.flag     = flag;
            r.last_pay = notified;
            awaited_reports.push_back(r);
        endfunction

        function string describe(t_report r);
            return $sformatf({"present %0b dist %0d pay %0d age %0d changed %0b",
                              " expired %04h present_mask %04h flag %0b last %0d"},
                             r.present, r.distance, r.pay, r.age, r.changed,
                             r.expired, r.present_mask, r.flag, r.last_pay);
        endfunction

        function void flag_mismatch(string what, t_report want, t_report got);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
                $display("[%0t] mismatch: %s", $time, what);
                $display("    expected %s", describe(want));
                $display("    actual   %s", describe(got));
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            string   bad;
            if (awaited_reports.size() == 0) begin
                flag_mismatch("result beat with nothing outstanding", '0, got);
                return;
            end
            want = awaited_reports.pop_front();
            bad  = "";
            if (got.present      !== want.present)      bad = {bad, " entry_present"};
            if (got.distance     !== want.distance)     bad = {bad, " entry_distance"};
            if (got.pay          !== want.pay)          bad = {bad, " entry_payload"};
            if (got.age          !== want.age)          bad = {bad, " entry_age"};
            if (got.changed      !== want.changed)      bad = {bad, " payload_changed"};
            if (got.expired      !== want.expired)      bad = {bad, " expired_mask"};
            if (got.present_mask !== want.present_mask) bad = {bad, " present_mask"};
            if (got.flag         !== want.flag)         bad = {bad, " new_message_flag"};
            if (got.last_pay     !== want.last_pay)     bad = {bad, " last_payload"};
            if (bad != "") flag_mismatch({"field(s)", bad}, want, got);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block and its surroundings
    // ------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    nawa_in_if  item_bus ();
    nawa_out_if result_bus ();

    neighbour_archive_with_aging DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    table_tracker tracker = new();

    int register_faults = 0;
    int long_holds      = 0;
    int hold_request    = 0;    // set by the stimulus, consumed by the receiver
    bit steady_source   = 1'b0; // no idle gaps on the input side
    bit steady_sink     = 1'b0; // no stalls on the result side
    bit crowd           = 1'b0; // back-to-back beats while the receiver holds off

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge, i.e. the values
    // that were stable during the cycle just ended.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_report seen;
        t_beat   taken;
        if (i_rst_n === 1'b1) begin
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
                seen = '{present:      result_bus.entry_present,
                         distance:     result_bus.entry_distance,
                         pay:          result_bus.entry_payload,
                         age:          result_bus.entry_age,
                         changed:      result_bus.payload_changed,
                         expired:      result_bus.expired_mask,
                         present_mask: result_bus.present_mask,
                         flag:         result_bus.new_message_flag,
                         last_pay:     result_bus.last_payload};
                tracker.check_report(seen);
            end
            if (item_bus.valid === 1'b1 && item_bus.ready === 1'b1) begin
                taken.op   = t_op'(item_bus.operation);
                taken.raw  = item_bus.raw_message;
                taken.meas = item_bus.measured_distance;
                taken.idx  = item_bus.entry_index;
                tracker.note_beat(taken);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a fresh stall per result beat; a requested long hold-off
    // is counted out here while the sender keeps pushing.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        result_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
                long_holds++;
            end else begin
                hold = steady_sink ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold > 0) begin
                result_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge i_clk); while (result_bus.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Each is entered just after a rising edge.
    // ------------------------------------------------------------------

    // setup, access, then idle with psel low so back-to-back calls never
    // drive psel twice in one step
    task automatic apb_access(logic wr, logic [APB_AW-1:0] addr,
                              logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write one register, mirror it in the shadow and read it back
    task automatic set_register(logic idx, logic [APB_DW-1:0] value, int width);
        logic [APB_DW-1:0] back;
        logic [APB_DW-1:0] keep;
        keep = (APB_DW'(1) << width) - 1;
        apb_access(1'b1, {idx, 2'b00}, value, back);
        tracker.set_register(idx, value);
        apb_access(1'b0, {idx, 2'b00}, '0, back);
        if ((back & keep) !== (value & keep)) begin
            register_faults++;
            $display("[%0t] register %0d reads %0h, written %0h", $time, idx,
                     back & keep, value & keep);
        end
    endtask

    task automatic program_table(logic [LIFE_W-1:0] life, logic [PAY_W-1:0] code);
        set_register(REG_LIFETIME, APB_DW'(life), LIFE_W);
        set_register(REG_PING, APB_DW'(code), PAY_W);
    endtask

    // drop valid, wait for every outstanding report, then let the walk finish
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (tracker.awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one beat and hold it until the block takes it; valid stays up
    // into the next beat when no gap is drawn
    task automatic send_beat(t_beat b);
        int gap;
        gap = (steady_source || crowd) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid             <= 1'b1;
        item_bus.operation         <= b.op;
        item_bus.raw_message       <= b.raw;
        item_bus.measured_distance <= b.meas;
        item_bus.entry_index       <= b.idx;
        do @(posedge i_clk); while (item_bus.ready !== 1'b1);
    endtask

    function automatic t_beat make_beat(t_op op, logic [RAW_W-1:0] raw,
                                        logic [DIST_W-1:0] meas, logic [ID_W-1:0] idx);
        t_beat b;
        b.op   = op;
        b.raw  = raw;
        b.meas = meas;
        b.idx  = idx;
        return b;
    endfunction

    // Random beat. Unused fields carry noise. Receives lean towards the
    // ping code, the void payload and the payload already held, so the
    // unchanged and not-notified paths get plenty of traffic.
    function automatic t_beat random_beat(int tick_share);
        t_beat            b;
        int               roll;
        logic [ID_W-1:0]  snd;
        logic [PAY_W-1:0] p;
        b.raw  = RAW_W'($urandom_range(0, 255));
        b.meas = DIST_W'($urandom_range(0, 255));
        b.idx  = ID_W'($urandom_range(0, 15));
        roll   = $urandom_range(0, 99);
        if (roll < tick_share)           b.op = OP_TICK;
        else if (roll < tick_share + 20) b.op = OP_READ;
        else if (roll < tick_share + 28) b.op = OP_ACK;
        else                             b.op = OP_RECEIVE;
        if (b.op == OP_RECEIVE) begin
            snd = b.raw[RAW_W-1 -: ID_W];
            case ($urandom_range(0, 9))
                0, 1:    p = tracker.ping;
                2:       p = VOID_PAYLOAD;
                3, 4:    p = (int'(snd) < NEIGHBOUR_COUNT) ? tracker.pay[snd] : VOID_PAYLOAD;
                default: p = PAY_W'($urandom_range(0, 15));
            endcase
            b.raw = {snd, p};
            case ($urandom_range(0, 9))
                0:       b.meas = UNKNOWN_DISTANCE;
                1:       b.meas = '0;
                default: b.meas = DIST_W'($urandom_range(0, 255));
            endcase
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int tick_share;
        i_rst_n                    = 1'b0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        item_bus.valid             = 1'b0;
        item_bus.operation         = OP_RECEIVE;
        item_bus.raw_message       = '0;
        item_bus.measured_distance = '0;
        item_bus.entry_index       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values: empty reads, void and ping
        // payloads, distance extremes, unchanged payload, acknowledge
        send_beat(make_beat(OP_READ,    8'h00, 8'h00, 4'd0));
        send_beat(make_beat(OP_READ,    8'hFF, 8'hFF, 4'd15));
        send_beat(make_beat(OP_RECEIVE, 8'h00, 8'd0,   4'd0));
        send_beat(make_beat(OP_RECEIVE, 8'hFF, 8'd254, 4'd15));
        send_beat(make_beat(OP_RECEIVE, {4'd3, PING_RESET}, UNKNOWN_DISTANCE, 4'd0));
        send_beat(make_beat(OP_RECEIVE, 8'hFF, 8'd7,   4'd0));
        send_beat(make_beat(OP_READ,    8'h00, 8'h00, 4'd15));
        send_beat(make_beat(OP_READ,    8'h00, 8'h00, 4'd3));
        send_beat(make_beat(OP_ACK,     8'hA5, 8'h5A, 4'd9));
        send_beat(make_beat(OP_READ,    8'h00, 8'h00, 4'd0));
        send_beat(make_beat(OP_TICK,    8'h33, 8'hCC, 4'd6));
        send_beat(make_beat(OP_RECEIVE, 8'h7A, 8'd128, 4'd0));
        send_beat(make_beat(OP_RECEIVE, 8'h70, 8'd128, 4'd0));
        send_beat(make_beat(OP_TICK,    8'h00, 8'h00, 4'd0));
        send_beat(make_beat(OP_READ,    8'h00, 8'h00, 4'd7));
        send_beat(make_beat(OP_ACK,     8'h00, 8'h00, 4'd0));

        // lifetime 0 expires anything already aged; ping code equal to void
        settle();
        program_table(8'd0, VOID_PAYLOAD);
        send_beat(make_beat(OP_RECEIVE, 8'h55, 8'd1,  4'd0));
        send_beat(make_beat(OP_RECEIVE, 8'h50, 8'd2,  4'd0));
        send_beat(make_beat(OP_TICK,    8'h00, 8'h00, 4'd0));
        send_beat(make_beat(OP_TICK,    8'h00, 8'h00, 4'd0));
        send_beat(make_beat(OP_READ,    8'h00, 8'h00, 4'd5));
        send_beat(make_beat(OP_RECEIVE, 8'h5C, 8'd3,  4'd0));
        send_beat(make_beat(OP_READ,    8'h00, 8'h00, 4'd5));
        send_beat(make_beat(OP_ACK,     8'h00, 8'h00, 4'd0));

        // age ceiling: with lifetime 255 the age sticks at 255 and the entry
        // lives on; dropping the lifetime to 254 then expires it
        settle();
        program_table(8'd255, PING_RESET);
        send_beat(make_beat(OP_RECEIVE, 8'h29, 8'd40, 4'd0));
        repeat (int'(AGE_MAX) + 5)
            send_beat(make_beat(OP_TICK, RAW_W'($urandom_range(0, 255)),
                                DIST_W'($urandom_range(0, 255)),
                                ID_W'($urandom_range(0, 15))));
        send_beat(make_beat(OP_READ, 8'h00, 8'h00, 4'd2));
        settle();
        program_table(8'd254, PING_RESET);
        send_beat(make_beat(OP_TICK, 8'h00, 8'h00, 4'd0));
        send_beat(make_beat(OP_READ, 8'h00, 8'h00, 4'd2));

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       program_table(LIFETIME_RESET, PING_RESET);
                1:       program_table(8'd254, 4'd15);
                2:       program_table(8'd0, PAY_W'($urandom_range(0, 15)));
                3:       program_table(LIFE_W'($urandom_range(1, 8)),
                                       PAY_W'($urandom_range(0, 15)));
                4:       program_table(8'd255, PAY_W'($urandom_range(0, 15)));
                5:       program_table(LIFE_W'($urandom_range(0, 30)), VOID_PAYLOAD);
                6:       program_table(8'd3, PAY_W'($urandom_range(0, 15)));
                default: program_table(LIFE_W'($urandom_range(0, 254)),
                                       PAY_W'($urandom_range(0, 15)));
            endcase
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
            tick_share    = $urandom_range(15, 45);
            // one phase backs the block up: the receiver sits out a long
            // stretch while beats keep coming with no gaps
            if (ph == 6) begin
                hold_request = LONG_HOLD;
                crowd        = 1'b1;
            end
            for (int n = 0; n < RANDOM_BEATS / PHASES; n++) begin
                if (n == CROWD_BEATS) crowd = 1'b0;
                send_beat(random_beat(tick_share));
            end
            crowd = 1'b0;
        end

        settle();
        $display("covered %0d beats: %0d receives, %0d ticks, %0d reads, %0d acknowledges",
                 tracker.op_seen[0] + tracker.op_seen[1] + tracker.op_seen[2] +
                 tracker.op_seen[3], tracker.op_seen[int'(OP_RECEIVE)],
                 tracker.op_seen[int'(OP_TICK)], tracker.op_seen[int'(OP_READ)],
                 tracker.op_seen[int'(OP_ACK)]);
        $display({"%0d expiries, %0d notifications, %0d register writes,",
                  " %0d long stalls, %0d mismatches"},
                 tracker.expiries, tracker.notifications, tracker.settings, long_holds,
                 tracker.mismatches + register_faults);
        if (tracker.mismatches == 0 && register_faults == 0 &&
            tracker.awaited_reports.size() == 0) begin
            $display("neighbour_archive_with_aging regression: pass");
        end else begin
            $display("neighbour_archive_with_aging regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Watchdog: several times the slowest legal run
    // ------------------------------------------------------------------
    initial begin : watchdog
        #(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
        $display("watchdog expired, %0d reports outstanding", tracker.awaited_reports.size());
        $display("neighbour_archive_with_aging regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/nawa_pkg.sv
design/nawa_if.sv
design/nawa_ctrl.sv
design/nawa_dp.sv
design/neighbour_archive_with_aging.sv
design/nawa_chk.sv
bench/neighbour_archive_with_aging_tb.sv
